>>> sv/lhes_pkg.sv
// ----------------------------------------------------------------------------
// lhes_pkg
// Shared types and constants of the lattice hopping event step.
// ----------------------------------------------------------------------------
package lhes_pkg;

  localparam int MAX_SITES   = 1024;
  localparam int NUM_SITES   = MAX_SITES + 3;
  localparam int NUM_ENTRIES = 4 * NUM_SITES;
  localparam int TREE_AW     = $clog2(NUM_ENTRIES);
  localparam int TREE_SIZE   = 1 << TREE_AW;
  localparam int SITE_W      = 11;
  localparam int RATE_W      = 32;
  localparam int SUM_W       = 48;
  localparam int WAIT_W      = 40;
  localparam int NUM_REGS    = 6;
  localparam int PADDR_W     = 5;

  localparam logic [RATE_W-1:0] LN2_Q32  = 32'd2977044472;
  localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

  localparam logic STATUS_EVENT = 1'b0;
  localparam logic STATUS_NONE  = 1'b1;

  typedef enum logic [1:0] {
    ACT_BIND,
    ACT_UNBIND,
    ACT_HOP,
    ACT_DEACT
  } lhes_act_e;

  typedef struct packed {
    logic [SITE_W-1:0] n;
    logic [RATE_W-1:0] bind_rate;
    logic [RATE_W-1:0] unbind_rate;
    logic [RATE_W-1:0] hop_rate;
    logic [RATE_W-1:0] boosted_rate;
    logic [RATE_W-1:0] deact_rate;
  } lhes_cfg_t;

  typedef struct packed {
    logic              done;
    lhes_act_e         action;
    logic [SITE_W-1:0] site;
  } lhes_evt_t;

endpackage

>>> sv/lhes_wait.sv
// ----------------------------------------------------------------------------
// lhes_wait
// Wait time unit: -ln(u/2^32) by normalize and square, times 2^8, divided
// by the total rate one quotient bit per cycle, saturated to Q16.24.
// ----------------------------------------------------------------------------
module lhes_wait import lhes_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [31:0]       u_i,
  input  logic [SUM_W-1:0]  total_i,
  output logic              done_o,
  output logic [WAIT_W-1:0] wait_o
);

  localparam int NUM_W = 46;
  localparam int CNT_W = 6;

  typedef enum logic [2:0] {
    W_IDLE, W_NORM, W_SQ, W_LN1, W_LN2, W_DIV, W_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [31:0]        x_q, x_d;
  logic [4:0]         z_q, z_d;
  logic [31:0]        frac_q, frac_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [37:0]        ph_q, ph_d;
  logic [63:0]        pl_q, pl_d;
  logic [NUM_W-1:0]   num_q, num_d;
  logic [NUM_W-1:0]   quo_q, quo_d;
  logic [SUM_W-1:0]   rem_q, rem_d;
  logic [SUM_W-1:0]   den_q, den_d;

  logic [63:0]        sq;
  logic [32:0]        sq_top;
  logic [37:0]        l2;
  logic [37:0]        ln;
  logic [SUM_W:0]     rsh;

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    z_d     = z_q;
    frac_d  = frac_q;
    cnt_d   = cnt_q;
    ph_d    = ph_q;
    pl_d    = pl_q;
    num_d   = num_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    sq      = 64'(x_q) * 64'(x_q);
    sq_top  = sq[63:31];
    l2      = {6'(z_q) + 6'd1, 32'd0} - 38'(frac_q);
    ln      = ph_q + 38'(pl_q[63:32]);
    rsh     = {rem_q, num_q[NUM_W-1]};
    unique case (state_q)
      W_IDLE: begin
        if (start_i) begin
          x_d     = (u_i == 32'd0) ? 32'd1 : u_i;
          z_d     = 5'd0;
          den_d   = total_i;
          state_d = W_NORM;
        end
      end
      W_NORM: begin
        if (x_q[31]) begin
          cnt_d   = '0;
          frac_d  = '0;
          state_d = W_SQ;
        end else begin
          x_d = {x_q[30:0], 1'b0};
          z_d = z_q + 5'd1;
        end
      end
      W_SQ: begin
        if (sq_top[32]) begin
          x_d    = sq_top[32:1];
          frac_d = {frac_q[30:0], 1'b1};
        end else begin
          x_d    = sq_top[31:0];
          frac_d = {frac_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(31)) state_d = W_LN1;
      end
      W_LN1: begin
        ph_d    = 38'(l2[37:32]) * 38'(LN2_Q32);
        pl_d    = 64'(l2[31:0]) * 64'(LN2_Q32);
        state_d = W_LN2;
      end
      W_LN2: begin
        num_d   = {ln, 8'd0};
        rem_d   = '0;
        quo_d   = '0;
        cnt_d   = '0;
        state_d = W_DIV;
      end
      W_DIV: begin
        if (rsh >= {1'b0, den_q}) begin
          rem_d = SUM_W'(rsh - {1'b0, den_q});
          quo_d = {quo_q[NUM_W-2:0], 1'b1};
        end else begin
          rem_d = rsh[SUM_W-1:0];
          quo_d = {quo_q[NUM_W-2:0], 1'b0};
        end
        num_d = {num_q[NUM_W-2:0], 1'b0};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) state_d = W_DONE;
      end
      W_DONE: state_d = W_IDLE;
      default: state_d = W_IDLE;
    endcase
  end

  assign done_o = (state_q == W_DONE);
  assign wait_o = (quo_q > NUM_W'(WAIT_MAX)) ? WAIT_MAX : quo_q[WAIT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    z_q    <= z_d;
    frac_q <= frac_d;
    cnt_q  <= cnt_d;
    ph_q   <= ph_d;
    pl_q   <= pl_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

endmodule

>>> sv/lhes_lattice.sv
// ----------------------------------------------------------------------------
// lhes_lattice
// Lattice state in three memories: occupancy, rate table and a Fenwick tree
// of the rates. Init sweep, event search by tree descent, and read-modify-
// write of the touched rates with tree updates.
// ----------------------------------------------------------------------------
module lhes_lattice import lhes_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lhes_cfg_t        cfg_i,
  input  logic             init_i,
  input  logic             start_i,
  input  logic [31:0]      pick_i,
  output logic             ready_o,
  output logic [SUM_W-1:0] total_o,
  output lhes_evt_t        evt_o
);

  localparam int BIT_W = $clog2(TREE_AW);
  localparam int JW    = TREE_AW + 2;
  localparam int CW    = TREE_AW + 1;
  localparam int TW    = SITE_W + 1;

  typedef enum logic [3:0] {
    L_INIT, L_IDLE, L_MUL1, L_MUL2, L_SRD, L_SCMP, L_OA, L_OB, L_OC,
    L_OD, L_OE, L_ERD, L_EWR, L_FT, L_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [TREE_AW-1:0] sweep_q, sweep_d;
  logic [SUM_W-1:0]   total_q, total_d;
  logic [31:0]        pick_q, pick_d;
  logic [SUM_W-1:0]   ph_q, ph_d;
  logic [63:0]        pl_q, pl_d;
  logic [SUM_W-1:0]   rem_q, rem_d;
  logic [TREE_AW-1:0] pos_q, pos_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic               om1_q, om1_d, op1_q, op1_d, op2_q, op2_d;
  logic [3:0]         k_q, k_d;
  logic [SUM_W-1:0]   delta_q, delta_d;
  logic [JW-1:0]      j_q, j_d;

  // memories
  logic [SUM_W-1:0]   tree_mem [TREE_SIZE];
  logic [RATE_W-1:0]  rate_mem [NUM_ENTRIES];
  logic               occ_mem  [NUM_SITES];

  logic               tree_we, tree_re, rate_we, rate_re, occ_we, occ_re;
  logic [TREE_AW-1:0] tree_wa, tree_ra, rate_wa, rate_ra;
  logic [SITE_W-1:0]  occ_wa, occ_ra;
  logic [SUM_W-1:0]   tree_wd, tree_rd_q;
  logic [RATE_W-1:0]  rate_wd, rate_rd_q;
  logic               occ_wd, occ_rd_q;

  logic [SITE_W-1:0]  site;
  lhes_act_e          act;
  logic [TREE_AW-1:0] cand;
  logic [TREE_AW-1:0] entry;
  logic [TW-1:0]      tsite;
  logic               ghost;
  logic [RATE_W-1:0]  new_v;
  logic [SUM_W-1:0]   delta_now;
  logic [JW-1:0]      j_next;
  logic [CW-1:0]      init_cnt;
  logic [SITE_W-1:0]  sw_site;

  assign site = pos_q[TREE_AW-1:2];
  assign act  = lhes_act_e'(pos_q[1:0]);
  assign cand = pos_q | (TREE_AW'(1) << bit_q);

  // number of bind entries covered by tree node at this address
  function automatic logic [CW-1:0] node_count(input logic [TREE_AW-1:0] addr,
                                               input logic [SITE_W-1:0]  n);
    logic [CW-1:0] j, lb, lo, smin, smax;
    begin
      j    = (addr == '0) ? CW'(TREE_SIZE) : CW'(addr);
      lb   = j & (~j + CW'(1));
      lo   = j - lb;
      smin = (lo + CW'(3)) >> 2;
      if (smin < CW'(1)) smin = CW'(1);
      smax = (j - CW'(1)) >> 2;
      if (smax > CW'(n)) smax = CW'(n);
      node_count = (smax >= smin) ? (smax - smin + CW'(1)) : '0;
    end
  endfunction

  function automatic logic [RATE_W-1:0] new_rate(input logic [3:0]        k,
                                                 input logic [RATE_W-1:0] old,
                                                 input lhes_act_e         a,
                                                 input logic              om1,
                                                 input logic              op1,
                                                 input logic              op2,
                                                 input lhes_cfg_t         c);
    logic [RATE_W-1:0] v;
    begin
      v = old;
      case (k[3:2])
        2'd0: begin
          if (k[1:0] == 2'd2) v = (a == ACT_BIND || !om1) ? '0 : c.hop_rate;
        end
        2'd1: begin
          case (a) inside
            ACT_BIND: begin
              case (k[1:0])
                2'd1:    v = c.unbind_rate;
                2'd2:    v = op1 ? '0 : c.hop_rate;
                default: v = '0;
              endcase
            end
            ACT_UNBIND, ACT_HOP: begin
              case (k[1:0])
                2'd0:    v = c.boosted_rate;
                2'd3:    v = c.deact_rate;
                default: v = '0;
              endcase
            end
            default: v = (k[1:0] == 2'd0) ? c.bind_rate : '0;
          endcase
        end
        2'd2: begin
          if (a == ACT_HOP) begin
            case (k[1:0])
              2'd1:    v = c.unbind_rate;
              2'd2:    v = op2 ? '0 : c.hop_rate;
              default: v = '0;
            endcase
          end
        end
        default: v = old;
      endcase
      new_rate = v;
    end
  endfunction

  assign entry     = TREE_AW'({site, 2'b00}) - TREE_AW'(4) + TREE_AW'(k_q);
  assign tsite     = TW'(site) - TW'(1) + TW'(k_q[3:2]);
  assign ghost     = (tsite == '0) || (tsite > TW'(cfg_i.n));
  assign new_v     = ghost ? '0 : new_rate(k_q, rate_rd_q, act, om1_q, op1_q, op2_q,
                                           cfg_i);
  assign delta_now = SUM_W'(new_v) - SUM_W'(rate_rd_q);
  assign j_next    = j_q + (j_q & (~j_q + JW'(1)));
  assign init_cnt  = node_count(sweep_q, cfg_i.n);
  assign sw_site   = sweep_q[TREE_AW-1:2];

  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    total_d = total_q;
    pick_d  = pick_q;
    ph_d    = ph_q;
    pl_d    = pl_q;
    rem_d   = rem_q;
    pos_d   = pos_q;
    bit_d   = bit_q;
    om1_d   = om1_q;
    op1_d   = op1_q;
    op2_d   = op2_q;
    k_d     = k_q;
    delta_d = delta_q;
    j_d     = j_q;
    tree_we = 1'b0;  tree_wa = sweep_q;  tree_wd = '0;
    tree_re = 1'b0;  tree_ra = cand;
    rate_we = 1'b0;  rate_wa = entry;    rate_wd = new_v;
    rate_re = 1'b0;  rate_ra = entry;
    occ_we  = 1'b0;  occ_wa  = site;     occ_wd  = 1'b0;
    occ_re  = 1'b0;  occ_ra  = site - SITE_W'(1);
    unique case (state_q)
      L_INIT: begin
        tree_we = 1'b1;
        tree_wd = SUM_W'(init_cnt) * SUM_W'(cfg_i.bind_rate);
        rate_we = (sweep_q < TREE_AW'(NUM_ENTRIES));
        rate_wa = sweep_q;
        rate_wd = (sweep_q[1:0] == 2'd0 && sw_site != '0 && sw_site <= cfg_i.n)
                  ? cfg_i.bind_rate : '0;
        occ_we  = (sweep_q < TREE_AW'(NUM_SITES));
        occ_wa  = sweep_q[SITE_W-1:0];
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == TREE_AW'(TREE_SIZE - 1)) begin
          total_d = SUM_W'(cfg_i.n) * SUM_W'(cfg_i.bind_rate);
          state_d = L_IDLE;
        end
      end
      L_IDLE: begin
        if (start_i) begin
          pick_d  = pick_i;
          state_d = L_MUL1;
        end
      end
      L_MUL1: begin
        ph_d    = SUM_W'(pick_q) * SUM_W'(total_q[SUM_W-1:32]);
        pl_d    = 64'(pick_q) * 64'(total_q[31:0]);
        state_d = L_MUL2;
      end
      L_MUL2: begin
        rem_d   = ph_q + SUM_W'(pl_q[63:32]);
        pos_d   = '0;
        bit_d   = BIT_W'(TREE_AW - 1);
        state_d = L_SRD;
      end
      L_SRD: begin
        tree_re = 1'b1;
        state_d = L_SCMP;
      end
      L_SCMP: begin
        // descend: take the node while its sum fits in the remainder
        if (tree_rd_q <= rem_q) begin
          pos_d = cand;
          rem_d = rem_q - tree_rd_q;
        end
        if (bit_q == '0) begin
          state_d = L_OA;
        end else begin
          bit_d   = bit_q - 1'b1;
          state_d = L_SRD;
        end
      end
      L_OA: begin
        occ_re  = 1'b1;
        state_d = L_OB;
      end
      L_OB: begin
        om1_d   = occ_rd_q;
        occ_re  = 1'b1;
        occ_ra  = site + SITE_W'(1);
        state_d = L_OC;
      end
      L_OC: begin
        op1_d   = occ_rd_q;
        occ_re  = 1'b1;
        occ_ra  = site + SITE_W'(2);
        state_d = L_OD;
      end
      L_OD: begin
        op2_d   = occ_rd_q;
        occ_we  = (act != ACT_DEACT);
        occ_wd  = (act == ACT_BIND);
        state_d = L_OE;
      end
      L_OE: begin
        occ_we  = (act == ACT_HOP) && (TW'(site) + TW'(1) <= TW'(cfg_i.n));
        occ_wa  = site + SITE_W'(1);
        occ_wd  = 1'b1;
        k_d     = '0;
        state_d = L_ERD;
      end
      L_ERD: begin
        rate_re = 1'b1;
        state_d = L_EWR;
      end
      L_EWR: begin
        rate_we = 1'b1;
        delta_d = delta_now;
        total_d = total_q + delta_now;
        if (delta_now != '0) begin
          j_d     = JW'(entry) + JW'(1);
          tree_re = 1'b1;
          tree_ra = TREE_AW'(JW'(entry) + JW'(1));
          state_d = L_FT;
        end else if (k_q == 4'd11) begin
          state_d = L_DONE;
        end else begin
          k_d     = k_q + 4'd1;
          state_d = L_ERD;
        end
      end
      L_FT: begin
        tree_we = 1'b1;
        tree_wa = j_q[TREE_AW-1:0];
        tree_wd = tree_rd_q + delta_q;
        if (j_next <= JW'(TREE_SIZE)) begin
          j_d     = j_next;
          tree_re = 1'b1;
          tree_ra = j_next[TREE_AW-1:0];
        end else if (k_q == 4'd11) begin
          state_d = L_DONE;
        end else begin
          k_d     = k_q + 4'd1;
          state_d = L_ERD;
        end
      end
      L_DONE: state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
    if (init_i) begin
      sweep_d = '0;
      state_d = L_INIT;
    end
  end

  assign ready_o      = (state_q == L_IDLE);
  assign total_o      = total_q;
  assign evt_o.done   = (state_q == L_DONE);
  assign evt_o.action = act;
  assign evt_o.site   = site;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_INIT;
      sweep_q <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q  <= pick_d;
    ph_q    <= ph_d;
    pl_q    <= pl_d;
    rem_q   <= rem_d;
    pos_q   <= pos_d;
    bit_q   <= bit_d;
    om1_q   <= om1_d;
    op1_q   <= op1_d;
    op2_q   <= op2_d;
    k_q     <= k_d;
    delta_q <= delta_d;
    j_q     <= j_d;
  end

  always_ff @(posedge clk_i) begin
    if (tree_we) tree_mem[tree_wa] <= tree_wd;
    if (tree_re) tree_rd_q <= tree_mem[tree_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rate_we) rate_mem[rate_wa] <= rate_wd;
    if (rate_re) rate_rd_q <= rate_mem[rate_ra];
  end

  always_ff @(posedge clk_i) begin
    if (occ_we) occ_mem[occ_wa] <= occ_wd;
    if (occ_re) occ_rd_q <= occ_mem[occ_ra];
  end

endmodule

>>> sv/lattice_hopping_event_step.sv
// ----------------------------------------------------------------------------
// lattice_hopping_event_step
// One kinetic Monte Carlo event per input word on a 1-D hopping lattice.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one word of two uniform
//   fractions; output channel (out_valid_o/out_ready_i) returns one word with
//   status, action, site and wait time for every input word.
//   Rates and lattice length are set over the APB port (register i at 4*i);
//   every write to a known register rebuilds the lattice with a sweep over
//   all 8192 entries of the Fenwick tree memory, during which in_ready_o is low.
//   The same sweep runs after reset.
//   With a zero total rate neither path runs and the result goes straight to
//   the output stage. Otherwise the wait path (normalize, 32 squarings,
//   46-step divide) runs beside the lattice path, which is a 13-step tree
//   descent plus a read-modify-write of 12 rate entries, each changed entry
//   walking up to 14 tree nodes.
//   One word is in work at a time; the next word is taken as soon as the
//   result sits in the output register, even if the receiver stalls. A
//   stalled result holds until out_ready_i.
// ----------------------------------------------------------------------------
module lattice_hopping_event_step import lhes_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        uniform_time_i,
  input  logic [31:0]        uniform_pick_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               status_o,
  output logic [1:0]         action_o,
  output logic [SITE_W-1:0]  site_o,
  output logic [WAIT_W-1:0]  wait_time_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // register indexes
  localparam logic [2:0] REG_LENGTH = 3'd0;
  localparam logic [2:0] REG_BIND   = 3'd1;
  localparam logic [2:0] REG_UNBIND = 3'd2;
  localparam logic [2:0] REG_HOP    = 3'd3;
  localparam logic [2:0] REG_BOOST  = 3'd4;
  localparam logic [2:0] REG_DEACT  = 3'd5;

  typedef enum logic [1:0] {T_IDLE, T_RUN, T_OUT} state_e;

  // configuration registers
  logic [SITE_W-1:0] length_q;
  logic [31:0]       bind_q, unbind_q, hop_q, boost_q, deact_q;
  logic [31:0]       boosted_q;
  logic [63:0]       boost_prod;
  logic [2:0]        reg_idx;
  logic              cfg_wr;
  logic              cfg_known;
  logic [SITE_W-1:0] n_used;
  lhes_cfg_t         cfg;

  // event control
  state_e            state_q, state_d;
  logic              lat_done_q, lat_done_d, wait_done_q, wait_done_d;
  logic              res_status_q, res_status_d;
  lhes_act_e         res_act_q, res_act_d;
  logic [SITE_W-1:0] res_site_q, res_site_d;
  logic [WAIT_W-1:0] res_wait_q, res_wait_d;
  logic              out_valid_q, out_valid_d;
  logic              status_q, status_d;
  lhes_act_e         action_q, action_d;
  logic [SITE_W-1:0] site_q, site_d;
  logic [WAIT_W-1:0] wait_q, wait_d;

  logic              accept;
  logic              run_start;
  logic              lat_ready;
  logic [SUM_W-1:0]  total;
  lhes_evt_t         evt;
  logic              wait_done;
  logic [WAIT_W-1:0] wait_val;

  // APB: always ready, writes land at the access phase
  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_wr    = psel & penable & pwrite;
  assign cfg_known = (reg_idx < 3'(NUM_REGS));

  always_comb begin
    unique case (reg_idx)
      REG_LENGTH: prdata = 32'(length_q);
      REG_BIND:   prdata = bind_q;
      REG_UNBIND: prdata = unbind_q;
      REG_HOP:    prdata = hop_q;
      REG_BOOST:  prdata = boost_q;
      REG_DEACT:  prdata = deact_q;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q <= SITE_W'(MAX_SITES);
      bind_q   <= 32'd65536;
      unbind_q <= 32'd65536;
      hop_q    <= 32'd65536;
      boost_q  <= 32'd65536;
      deact_q  <= 32'd65536;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LENGTH: length_q <= pwdata[SITE_W-1:0];
        REG_BIND:   bind_q   <= pwdata;
        REG_UNBIND: unbind_q <= pwdata;
        REG_HOP:    hop_q    <= pwdata;
        REG_BOOST:  boost_q  <= pwdata;
        REG_DEACT:  deact_q  <= pwdata;
        default: ;
      endcase
    end
  end

  // boosted bind rate, Q16.16 product truncated and saturated
  assign boost_prod = 64'(bind_q) * 64'(boost_q);
  always_ff @(posedge clk_i) begin
    boosted_q <= (boost_prod[63:48] != '0) ? '1 : boost_prod[47:16];
  end

  // clamp the length to 1..MAX_SITES
  assign n_used = (length_q == '0) ? SITE_W'(1) :
                  (length_q > SITE_W'(MAX_SITES)) ? SITE_W'(MAX_SITES) : length_q;

  assign cfg.n            = n_used;
  assign cfg.bind_rate    = bind_q;
  assign cfg.unbind_rate  = unbind_q;
  assign cfg.hop_rate     = hop_q;
  assign cfg.boosted_rate = boosted_q;
  assign cfg.deact_rate   = deact_q;

  assign in_ready_o = (state_q == T_IDLE) && lat_ready;
  assign accept     = in_valid_i & in_ready_o;
  assign run_start  = accept && (total != '0);

  lhes_lattice u_lattice (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .init_i  (cfg_wr && cfg_known),
    .start_i (run_start),
    .pick_i  (uniform_pick_i),
    .ready_o (lat_ready),
    .total_o (total),
    .evt_o   (evt)
  );

  lhes_wait u_wait (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (run_start),
    .u_i     (uniform_time_i),
    .total_i (total),
    .done_o  (wait_done),
    .wait_o  (wait_val)
  );

  always_comb begin
    state_d      = state_q;
    lat_done_d   = lat_done_q;
    wait_done_d  = wait_done_q;
    res_status_d = res_status_q;
    res_act_d    = res_act_q;
    res_site_d   = res_site_q;
    res_wait_d   = res_wait_q;
    out_valid_d  = out_valid_q;
    status_d     = status_q;
    action_d     = action_q;
    site_d       = site_q;
    wait_d       = wait_q;
    // drop the output word once taken
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    unique case (state_q)
      T_IDLE: begin
        if (accept) begin
          lat_done_d   = 1'b0;
          wait_done_d  = 1'b0;
          res_act_d    = ACT_BIND;
          res_site_d   = '0;
          res_wait_d   = '0;
          if (total == '0) begin
            res_status_d = STATUS_NONE;
            state_d      = T_OUT;
          end else begin
            res_status_d = STATUS_EVENT;
            state_d      = T_RUN;
          end
        end
      end
      T_RUN: begin
        if (evt.done) begin
          lat_done_d = 1'b1;
          res_act_d  = evt.action;
          res_site_d = evt.site;
        end
        if (wait_done) begin
          wait_done_d = 1'b1;
          res_wait_d  = wait_val;
        end
        if (lat_done_d && wait_done_d) state_d = T_OUT;
      end
      T_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_status_q;
          action_d    = res_act_q;
          site_d      = res_site_q;
          wait_d      = res_wait_q;
          state_d     = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= T_IDLE;
      lat_done_q   <= 1'b0;
      wait_done_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      res_status_q <= STATUS_EVENT;
      res_act_q    <= ACT_BIND;
      res_site_q   <= '0;
      res_wait_q   <= '0;
      status_q     <= STATUS_EVENT;
      action_q     <= ACT_BIND;
      site_q       <= '0;
      wait_q       <= '0;
    end else begin
      state_q      <= state_d;
      lat_done_q   <= lat_done_d;
      wait_done_q  <= wait_done_d;
      out_valid_q  <= out_valid_d;
      res_status_q <= res_status_d;
      res_act_q    <= res_act_d;
      res_site_q   <= res_site_d;
      res_wait_q   <= res_wait_d;
      status_q     <= status_d;
      action_q     <= action_d;
      site_q       <= site_d;
      wait_q       <= wait_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign action_o    = action_q;
  assign site_o      = site_q;
  assign wait_time_o = wait_q;

endmodule

>>> sv/lhes_checker.sv
// ----------------------------------------------------------------------------
// lhes_checker
// Port-level checks of the lattice hopping event step, bound to the top.
// ----------------------------------------------------------------------------
module lhes_checker import lhes_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [31:0]        uniform_time_i,
  input logic [31:0]        uniform_pick_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic               status_o,
  input logic [1:0]         action_o,
  input logic [SITE_W-1:0]  site_o,
  input logic [WAIT_W-1:0]  wait_time_o,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               pready
);

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({status_o, action_o, site_o, wait_time_o}))
    else $error("stalled output word changed");

  // a no-event word carries all zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_NONE |->
      action_o == ACT_BIND && site_o == '0 && wait_time_o == '0)
    else $error("no-event word with nonzero fields");

  // events only happen at real sites
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_EVENT |-> site_o != '0)
    else $error("event reported at ghost site");

  // a register write starts the rebuild sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && paddr[4:2] < 3'(NUM_REGS) |=> !in_ready_o)
    else $error("input taken during lattice rebuild");

  // one word in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while one is in work");

endmodule

bind lattice_hopping_event_step lhes_checker u_lhes_checker (.*);

>>> tb/sv/lhes_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhes_event_checker
// Watches the APB port and both word channels of the lattice event step,
// keeps its own lattice and rate table, predicts each result word and
// compares it against the block output.
// ----------------------------------------------------------------------------
module lhes_event_checker import lhes_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [31:0]        uniform_time_i,
  input  logic [31:0]        uniform_pick_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               status_i,
  input  logic [1:0]         action_i,
  input  logic [SITE_W-1:0]  site_i,
  input  logic [WAIT_W-1:0]  wait_time_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic               pready_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [31:0]        pwdata_i,
  output int                 err_cnt_o,
  output int                 pending_o
);

  typedef struct {
    logic              status;
    lhes_act_e         action;
    logic [SITE_W-1:0] site;
    logic [WAIT_W-1:0] wait_time;
  } event_word_t;

  event_word_t event_q[$];

  logic [10:0]       len_reg;
  logic [RATE_W-1:0] bind_reg, unbind_reg, hop_reg, boost_reg, deact_reg;
  logic              occ_mem [NUM_SITES];
  logic [RATE_W-1:0] rate_mem [NUM_ENTRIES];

  assign pending_o = event_q.size();

  function automatic int sites_used();
    if (len_reg < 1) return 1;
    if (len_reg > MAX_SITES) return MAX_SITES;
    return int'(len_reg);
  endfunction

  function automatic logic [RATE_W-1:0] boosted();
    logic [63:0] p;
    p = (64'(bind_reg) * 64'(boost_reg)) >> 16;
    return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  task automatic set_rate(int s, int a, logic [RATE_W-1:0] v);
    if (s >= 0 && s < NUM_SITES) rate_mem[4*s + a] = v;
  endtask

  task automatic set_occ(int s, logic v);
    if (s >= 0 && s < NUM_SITES) occ_mem[s] = v;
  endtask

  function automatic logic get_occ(int s);
    return (s >= 0 && s < NUM_SITES) ? occ_mem[s] : 1'b0;
  endfunction

  task automatic build_lattice();
    int n;
    n = sites_used();
    for (int s = 0; s < NUM_SITES; s++) occ_mem[s] = 1'b0;
    for (int i = 0; i < NUM_ENTRIES; i++) rate_mem[i] = '0;
    for (int s = 1; s <= n; s++) rate_mem[4*s] = bind_reg;
  endtask

  task automatic vacate(int s);
    set_rate(s - 1, 2, get_occ(s - 1) ? hop_reg : '0);
    set_rate(s, 0, boosted());
    set_rate(s, 1, '0);
    set_rate(s, 2, '0);
    set_rate(s, 3, deact_reg);
    set_occ(s, 1'b0);
  endtask

  task automatic occupy(int s);
    set_rate(s, 0, '0);
    set_rate(s, 1, unbind_reg);
    set_rate(s, 2, get_occ(s + 1) ? '0 : hop_reg);
    set_rate(s, 3, '0);
    set_occ(s, 1'b1);
  endtask

  // -ln(u / 2^32) in Q32.32 by squaring log2, truncating at each step
  function automatic logic [63:0] neg_ln_q32(logic [31:0] u);
    int p;
    logic [63:0] x, frac, l2, hi, lo;
    frac = '0;
    if (u == 0) u = 1;
    p = 31;
    while (u[p] == 1'b0) p--;
    x = 64'(u) << (31 - p);
    for (int i = 0; i < 32; i++) begin
      x = (x * x) >> 31;
      frac = frac << 1;
      if (x >= 64'h1_0000_0000) begin
        x = x >> 1;
        frac[0] = 1'b1;
      end
    end
    l2 = (64'(32 - p) << 32) - frac;
    hi = l2 >> 32;
    lo = l2 & 64'hFFFF_FFFF;
    return hi * 64'(LN2_Q32) + ((lo * 64'(LN2_Q32)) >> 32);
  endfunction

  task automatic predict_event(logic [31:0] ut, logic [31:0] up, output event_word_t w);
    logic [63:0] total, r2, acc, wt;
    int idx, s, n;
    total = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) total += 64'(rate_mem[i]);
    total &= 64'hFFFF_FFFF_FFFF;
    if (total == 0) begin
      w = '{STATUS_NONE, ACT_BIND, '0, '0};
      return;
    end
    r2 = 64'(up) * (total >> 32) + ((64'(up) * (total & 64'hFFFF_FFFF)) >> 32);
    // first entry whose running sum passes r2
    acc = '0;
    idx = NUM_ENTRIES - 1;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      acc += 64'(rate_mem[i]);
      if (acc > r2) begin
        idx = i;
        break;
      end
    end
    s = idx >> 2;
    wt = (neg_ln_q32(ut) << 8) / total;
    if (wt > 64'(WAIT_MAX)) wt = 64'(WAIT_MAX);
    w.status    = STATUS_EVENT;
    w.action    = lhes_act_e'(idx[1:0]);
    w.site      = s[SITE_W-1:0];
    w.wait_time = wt[WAIT_W-1:0];
    case (w.action)
      ACT_BIND: begin
        set_rate(s - 1, 2, '0);
        occupy(s);
      end
      ACT_UNBIND: vacate(s);
      ACT_HOP: begin
        vacate(s);
        occupy(s + 1);
      end
      default: begin
        set_rate(s, 0, bind_reg);
        set_rate(s, 1, '0);
        set_rate(s, 2, '0);
        set_rate(s, 3, '0);
        set_rate(s - 1, 2, get_occ(s - 1) ? hop_reg : '0);
      end
    endcase
    // ghosts stay empty, so a particle past the last site is gone
    n = sites_used();
    for (int a = 0; a < 4; a++) begin
      set_rate(0, a, '0);
      set_rate(n + 1, a, '0);
      set_rate(n + 2, a, '0);
    end
    set_occ(0, 1'b0);
    set_occ(n + 1, 1'b0);
    set_occ(n + 2, 1'b0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    event_word_t got, exp_w;
    if (!rst_ni) begin
      len_reg    = 11'd1024;
      bind_reg   = 32'd65536;
      unbind_reg = 32'd65536;
      hop_reg    = 32'd65536;
      boost_reg  = 32'd65536;
      deact_reg  = 32'd65536;
      build_lattice();
      event_q.delete();
      err_cnt_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && (paddr_i >> 2) < NUM_REGS) begin
        case (paddr_i >> 2)
          0: len_reg    = pwdata_i[10:0];
          1: bind_reg   = pwdata_i;
          2: unbind_reg = pwdata_i;
          3: hop_reg    = pwdata_i;
          4: boost_reg  = pwdata_i;
          default: deact_reg = pwdata_i;
        endcase
        build_lattice();
      end
      if (out_valid_i && out_ready_i) begin
        got = '{status_i, lhes_act_e'(action_i), site_i, wait_time_i};
        if (event_q.size() == 0) begin
          $display("%0t: result word with nothing expected: status %0d action %0d site %0d wait %0h",
                   $time, got.status, got.action, got.site, got.wait_time);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          exp_w = event_q.pop_front();
          if (got.status !== exp_w.status || got.action !== exp_w.action ||
              got.site !== exp_w.site || got.wait_time !== exp_w.wait_time) begin
            $display("%0t: mismatch expected status %0d action %0d site %0d wait %0h",
                     $time, exp_w.status, exp_w.action, exp_w.site, exp_w.wait_time);
            $display("%0t:          actual   status %0d action %0d site %0d wait %0h",
                     $time, got.status, got.action, got.site, got.wait_time);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_event(uniform_time_i, uniform_pick_i, exp_w);
        event_q.push_back(exp_w);
      end
    end
  end

endmodule

>>> tb/sv/tb_lattice_hopping_event_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lattice_hopping_event_step
// Drives fraction words and APB register writes into the lattice event step
// over several rate settings and idle patterns; the checker beside the block
// predicts every result word and counts mismatches.
// ----------------------------------------------------------------------------
module tb_lattice_hopping_event_step;
  import lhes_pkg::*;

  localparam int LATENCY_GAP = 400;

  // register indexes on the APB port
  localparam int REG_LEN    = 0;
  localparam int REG_BIND   = 1;
  localparam int REG_UNBIND = 2;
  localparam int REG_HOP    = 3;
  localparam int REG_BOOST  = 4;
  localparam int REG_DEACT  = 5;
  localparam int REG_NONE   = 6;

  // idle patterns
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [31:0]        uniform_time_i;
  logic [31:0]        uniform_pick_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               status_o;
  logic [1:0]         action_o;
  logic [SITE_W-1:0]  site_o;
  logic [WAIT_W-1:0]  wait_time_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int err_cnt;
  int pending_cnt;
  int send_idle_pct;
  int recv_stall_pct;

  lattice_hopping_event_step dut (.*);

  lhes_event_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .uniform_time_i(uniform_time_i),
    .uniform_pick_i(uniform_pick_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_i      (status_o),
    .action_i      (action_o),
    .site_i        (site_o),
    .wait_time_i   (wait_time_o),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .err_cnt_o     (err_cnt),
    .pending_o     (pending_cnt)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Stall the receiver at the phase's rate; zero percent means always ready.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Drop everything after a generous bound; a correct run ends far earlier.
  initial begin
    #50ms;
    $display("tb_lattice_hopping_event_step: errors");
    $finish;
  end

  task automatic set_idle(int mode);
    case (mode)
      IDLE_SEND: begin send_idle_pct = 66; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 66; end
      IDLE_BOTH: begin send_idle_pct = 23; recv_stall_pct = 23; end
      default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  // Hold until every result word is back, then let the block settle.
  task automatic drain_results();
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (LATENCY_GAP) @(posedge clk_i);
  endtask

  // Send one fraction word; valid stays high while the next word follows at once.
  task automatic send_word(logic [31:0] ut, logic [31:0] up);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    uniform_time_i <= ut;
    uniform_pick_i <= up;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic park_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // APB write with setup and access phases; the register takes the word on the access edge.
  task automatic reg_write(int idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * idx);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly full random fractions, some near the ends of the range.
  function automatic logic [31:0] pick_fraction();
    case ($urandom_range(9))
      0:       return $urandom_range(15);
      1:       return 32'hFFFF_FFFF - $urandom_range(15);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_phase(logic [31:0] len, logic [31:0] br, logic [31:0] ur,
                           logic [31:0] hr, logic [31:0] bb, logic [31:0] dr,
                           int items, int mode);
    drain_results();
    reg_write(REG_LEN, len);
    reg_write(REG_BIND, br);
    reg_write(REG_UNBIND, ur);
    reg_write(REG_HOP, hr);
    reg_write(REG_BOOST, bb);
    reg_write(REG_DEACT, dr);
    set_idle(mode);
    for (int i = 0; i < items; i++) send_word(pick_fraction(), pick_fraction());
    park_input();
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    uniform_time_i = '0;
    uniform_pick_i = '0;
    out_ready_i    = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words on the reset lattice: fraction extremes, zero time fraction,
    // the first three each sent only after the previous result is back, then a burst.
    set_idle(IDLE_NONE);
    send_word(32'h0000_0001, 32'h0000_0000);
    park_input();
    while (pending_cnt != 0) @(posedge clk_i);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    park_input();
    while (pending_cnt != 0) @(posedge clk_i);
    send_word(32'h0000_0000, 32'h8000_0000);
    park_input();
    while (pending_cnt != 0) @(posedge clk_i);
    for (int i = 0; i < 8; i++) send_word($urandom, 32'hFFFF_FFFF - i);
    park_input();

    // Short lattice with saturating boost, then an unused register index.
    run_phase(32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 10, IDLE_NONE);
    drain_results();
    reg_write(REG_NONE, 32'hDEAD_BEEF);
    for (int i = 0; i < 4; i++) send_word(32'h0000_0001, $urandom);
    park_input();

    // No binding anywhere: every word reports an empty total.
    run_phase(32'd5, 32'd0, $urandom, $urandom, $urandom, $urandom, 4, IDLE_NONE);

    run_phase(32'd1024, 32'd65536, 32'd65536, 32'd65536, 32'd65536, 32'd65536,
              300, IDLE_NONE);
    run_phase(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 100, IDLE_SEND);
    run_phase(32'd3, $urandom, $urandom, $urandom, $urandom, $urandom, 150, IDLE_RECV);
    run_phase(32'd2, 32'd4096, 32'd256, 32'h00FF_0000, 32'h0002_0000, 32'd8192,
              150, IDLE_BOTH);
    run_phase(32'd0, $urandom, $urandom, $urandom, $urandom, $urandom, 50, IDLE_NONE);
    run_phase(32'hFFFF_F7FF, $urandom, $urandom, $urandom, $urandom, $urandom,
              100, IDLE_SEND);
    run_phase(32'd5, 32'd0, $urandom, $urandom, $urandom, $urandom, 15, IDLE_RECV);
    // Bind only: each event occupies a site and the total falls with every word.
    run_phase(32'd1024, 32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 60, IDLE_BOTH);
    run_phase(32'd16, $urandom_range(200000), $urandom_range(200000),
              $urandom_range(200000), $urandom_range(200000), $urandom_range(200000),
              100, IDLE_NONE);

    drain_results();
    if (err_cnt == 0) begin
      $display("tb_lattice_hopping_event_step: clean");
    end else begin
      $display("tb_lattice_hopping_event_step: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/lhes_pkg.sv
sv/lhes_wait.sv
sv/lhes_lattice.sv
sv/lattice_hopping_event_step.sv
sv/lhes_checker.sv
tb/sv/lhes_event_checker.sv
tb/sv/tb_lattice_hopping_event_step.sv
